FILE: hw/rtl/pvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvl_pkg
// shared types and constants of the periodic voronoi cell labeler
// ----------------------------------------------------------------------------
package pvl_pkg;

  // fixed arithmetic widths (seed coordinates never exceed 32 bits)
  localparam int PROD_W = 49;   // (2*i+1) * cell_size
  localparam int CEN_W  = 50;   // origin + product/2
  localparam int DIFF_W = 52;   // centre - seed - offset
  localparam int SQ_W   = 64;   // saturated square

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELL_SIZE_X = 3'd2,
    REG_CELL_SIZE_Y = 3'd3,
    REG_PERIOD_X    = 3'd4,
    REG_PERIOD_Y    = 3'd5,
    REG_GRAIN_COUNT = 3'd6
  } reg_idx_t;

  // periodic image offset along one axis
  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } off_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CTR,
    ST_RUN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [30:0] cell_size_x;
    logic [30:0] cell_size_y;
    logic [30:0] period_x;
    logic [30:0] period_y;
    logic [8:0]  grain_count;
  } cfg_t;

  typedef struct packed {
    logic start;     // classify accepted: capture indices, clear best
    logic mul_en;    // centre product
    logic ctr_en;    // centre sum
    logic load_we;   // seed load transfer
    logic issue;     // one image enters the distance pipeline
    logic last;      // final image of the search
    off_t a;         // x offset of the issued image
    off_t b;         // y offset of the issued image
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // final image has passed the compare
  } dp_sts_t;

endpackage

FILE: hw/rtl/pvl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvl channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface pvl_cmd_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         seed_index;
  logic signed [31:0] seed_pos_x;
  logic signed [31:0] seed_pos_y;
  logic signed [15:0] cell_i;
  logic signed [15:0] cell_j;

  modport source (
    output valid, func, seed_index, seed_pos_x, seed_pos_y, cell_i, cell_j,
    input  ready
  );
  modport sink (
    input  valid, func, seed_index, seed_pos_x, seed_pos_y, cell_i, cell_j,
    output ready
  );
endinterface

interface pvl_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] grain_id;
  logic       found;

  modport source (output valid, grain_id, found, input ready);
  modport sink (input valid, grain_id, found, output ready);
endinterface

FILE: hw/rtl/periodic_voronoi_cell_labeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_voronoi_cell_labeler
// labels a grid cell with the nearest seed point over periodic images
// ----------------------------------------------------------------------------
// A load item (func 0) writes one seed entry; loads with
// seed_index at or above MAX_SEEDS are dropped. A classify item (func 1)
// forms the cell centre origin + (index + 0.5) * cell_size on both axes in
// Q16.16, then compares the squared distance to every seed in use
// (min(grain_count, MAX_SEEDS) = N) in all nine periodic images, keeping the
// first strict minimum. One image goes through the compare pipeline each
// cycle, paced by the single read port of the seed tables; with N = 0 a
// classify returns found = 0 without a search. Only one classify is in
// flight; the input is taken again once the result sits in the output
// register, which holds it until the sink takes the transfer. Configuration
// may be written only while the block is idle.
module periodic_voronoi_cell_labeler
  import pvl_pkg::*;
#(
  parameter int MAX_SEEDS   = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  pvl_cmd_if.sink     cmd,
  pvl_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int AW    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.cell_size_x <= 31'd65536;
      cfg.cell_size_y <= 31'd65536;
      cfg.period_x    <= '0;
      cfg.period_y    <= '0;
      cfg.grain_count <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:    cfg.origin_x    <= cfg_wdata;
        REG_ORIGIN_Y:    cfg.origin_y    <= cfg_wdata;
        REG_CELL_SIZE_X: cfg.cell_size_x <= cfg_wdata[30:0];
        REG_CELL_SIZE_Y: cfg.cell_size_y <= cfg_wdata[30:0];
        REG_PERIOD_X:    cfg.period_x    <= cfg_wdata[30:0];
        REG_PERIOD_Y:    cfg.period_y    <= cfg_wdata[30:0];
        REG_GRAIN_COUNT: cfg.grain_count <= cfg_wdata[8:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // seeds in use, clamped to the table depth
  logic [31:0]      gc32;
  logic [CNT_W-1:0] count;

  assign gc32  = 32'(cfg.grain_count);
  assign count = (gc32 > 32'(MAX_SEEDS)) ? CNT_W'(MAX_SEEDS) : gc32[CNT_W-1:0];

  // controller / datapath
  dp_cmd_t       dp_cmd;
  dp_sts_t       dp_sts;
  logic [AW-1:0] seed_n;
  logic          in_ready;
  logic          result_load;
  logic          slot_free;
  logic          have;
  logic [7:0]    best_id;

  pvl_ctrl #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cmd.valid),
    .in_func     (cmd.func),
    .count       (count),
    .sts         (dp_sts),
    .slot_free   (slot_free),
    .in_ready    (in_ready),
    .cmd         (dp_cmd),
    .n           (seed_n),
    .result_load (result_load)
  );

  pvl_datapath #(
    .MAX_SEEDS   (MAX_SEEDS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (dp_cmd),
    .n          (seed_n),
    .seed_index (cmd.seed_index),
    .seed_pos_x (cmd.seed_pos_x),
    .seed_pos_y (cmd.seed_pos_y),
    .cell_i     (cmd.cell_i),
    .cell_j     (cmd.cell_j),
    .sts        (dp_sts),
    .have       (have),
    .best_id    (best_id)
  );

  assign cmd.ready = in_ready;

  // output register: holds one result until its transfer completes
  logic       rsp_valid;
  logic [7:0] grain_id_r;
  logic       found_r;

  assign slot_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // no seeds in use leaves have low and the id cleared
  always_ff @(posedge clk) begin
    if (result_load) begin
      grain_id_r <= best_id;
      found_r    <= have;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.grain_id = grain_id_r;
  assign rsp.found    = found_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_load |-> (!rsp_valid || rsp.ready))
    else $error("result written over one still waiting");
`endif

endmodule

FILE: hw/rtl/pvl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvl_ctrl
// sequencer: walks seeds and their nine periodic images, one per cycle
// ----------------------------------------------------------------------------
module pvl_ctrl
  import pvl_pkg::*;
#(
  parameter int MAX_SEEDS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_func,
  input  logic [$clog2(MAX_SEEDS+1)-1:0]         count,
  input  dp_sts_t                                sts,
  input  logic                                   slot_free,
  output logic                                   in_ready,
  output dp_cmd_t                                cmd,
  output logic [((MAX_SEEDS>1)?$clog2(MAX_SEEDS):1)-1:0] n,
  output logic                                   result_load
);

  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int AW    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

  state_t state, state_next;
  logic [CNT_W-1:0] n_cnt;
  off_t a_cnt, b_cnt;
  logic classify_req;

  function automatic off_t off_step(input off_t o);
    off_t r;
    unique case (o)
      OFF_NEG:  r = OFF_ZERO;
      OFF_ZERO: r = OFF_POS;
      default:  r = OFF_NEG;
    endcase
    return r;
  endfunction

  assign classify_req = in_valid && (func_t'(in_func) == FUNC_CLASSIFY);
  assign n = n_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (classify_req) begin
          state_next = (count == '0) ? ST_RESULT : ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_CTR;
      ST_CTR:    state_next = ST_RUN;
      ST_RUN: begin
        if (cmd.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.a       = a_cnt;
    cmd.b       = b_cnt;
    in_ready    = 1'b0;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.start   = classify_req;
        cmd.load_we = in_valid && (func_t'(in_func) == FUNC_LOAD);
      end
      ST_MUL:    cmd.mul_en = 1'b1;
      ST_CTR:    cmd.ctr_en = 1'b1;
      ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.last  = ((n_cnt + CNT_W'(1)) == count) && (a_cnt == OFF_POS) &&
                    (b_cnt == OFF_POS);
      end
      ST_RESULT: result_load = slot_free;
      default: ;
    endcase
  end

  // seed outer, x offset middle, y offset inner
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt <= '0;
      a_cnt <= OFF_NEG;
      b_cnt <= OFF_NEG;
    end else if (cmd.start) begin
      n_cnt <= '0;
      a_cnt <= OFF_NEG;
      b_cnt <= OFF_NEG;
    end else if (cmd.issue) begin
      b_cnt <= off_step(b_cnt);
      if (b_cnt == OFF_POS) begin
        a_cnt <= off_step(a_cnt);
        if (a_cnt == OFF_POS) n_cnt <= n_cnt + CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (n_cnt < count))
    else $error("image issued past the seed count");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.last) |=> (state == ST_DRAIN && !cmd.issue))
    else $error("issue continued after the final image");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == ST_DRAIN))
    else $error("search completion outside drain");
`endif

endmodule

FILE: hw/rtl/pvl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvl_datapath
// seed tables, cell centre and the pipelined distance/compare unit
// ----------------------------------------------------------------------------
module pvl_datapath
  import pvl_pkg::*;
#(
  parameter int MAX_SEEDS   = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfg_t                                   cfg,
  input  dp_cmd_t                                cmd,
  input  logic [((MAX_SEEDS>1)?$clog2(MAX_SEEDS):1)-1:0] n,
  input  logic [7:0]                             seed_index,
  input  logic signed [31:0]                     seed_pos_x,
  input  logic signed [31:0]                     seed_pos_y,
  input  logic signed [15:0]                     cell_i,
  input  logic signed [15:0]                     cell_j,
  output dp_sts_t                                sts,
  output logic                                   have,
  output logic [7:0]                             best_id
);

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int SW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  typedef struct packed {
    logic valid;
    logic last;
    off_t a;
    off_t b;
  } tag_t;

  // seed tables
  logic [SW-1:0] mem_x [MAX_SEEDS];
  logic [SW-1:0] mem_y [MAX_SEEDS];
  logic [31:0]   idx32;
  logic          idx_ok;

  assign idx32  = 32'(seed_index);
  assign idx_ok = (idx32 < 32'(MAX_SEEDS));

  always_ff @(posedge clk) begin
    if (cmd.load_we && idx_ok) begin
      mem_x[idx32[AW-1:0]] <= seed_pos_x[SW-1:0];
      mem_y[idx32[AW-1:0]] <= seed_pos_y[SW-1:0];
    end
  end

  logic [SW-1:0] rd_x, rd_y;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_x <= mem_x[n];
      rd_y <= mem_y[n];
    end
  end

  // cell centre: origin + floor((2*idx+1)*cell_size / 2)
  logic signed [15:0]       ci_r, cj_r;
  logic signed [16:0]       t_x, t_y;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [CEN_W-1:0]  cen_x, cen_y;

  assign t_x = {ci_r, 1'b1};
  assign t_y = {cj_r, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ci_r <= cell_i;
      cj_r <= cell_j;
    end
    if (cmd.mul_en) begin
      prod_x <= t_x * $signed({1'b0, cfg.cell_size_x});
      prod_y <= t_y * $signed({1'b0, cfg.cell_size_y});
    end
    if (cmd.ctr_en) begin
      cen_x <= $signed({{(CEN_W-32){cfg.origin_x[31]}}, cfg.origin_x}) +
               $signed({{(CEN_W-PROD_W+1){prod_x[PROD_W-1]}}, prod_x[PROD_W-1:1]});
      cen_y <= $signed({{(CEN_W-32){cfg.origin_y[31]}}, cfg.origin_y}) +
               $signed({{(CEN_W-PROD_W+1){prod_y[PROD_W-1]}}, prod_y[PROD_W-1:1]});
    end
  end

  // distance pipeline
  tag_t tag1, tag2, tag3, tag4, tag5;
  logic [AW-1:0] n1, n2, n3, n4, n5;
  logic done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1   <= '0;
      tag2   <= '0;
      tag3   <= '0;
      tag4   <= '0;
      tag5   <= '0;
      done_r <= 1'b0;
    end else begin
      tag1   <= '{valid: cmd.issue, last: cmd.last, a: cmd.a, b: cmd.b};
      tag2   <= tag1;
      tag3   <= tag2;
      tag4   <= tag3;
      tag5   <= tag4;
      done_r <= tag5.valid && tag5.last;
    end
  end

  logic signed [DIFF_W-1:0] sx_ext, sy_ext, cx_ext, cy_ext, px_ext, py_ext;
  logic signed [DIFF_W-1:0] off_x, off_y;
  logic signed [DIFF_W-1:0] base_x, base_y, dx, dy;
  logic [DIFF_W-1:0]        mag_x, mag_y;
  logic [SQ_W-1:0]          sq_x, sq_y;
  logic                     sat_x, sat_y;

  assign sx_ext = $signed({{(DIFF_W-SW){rd_x[SW-1]}}, rd_x});
  assign sy_ext = $signed({{(DIFF_W-SW){rd_y[SW-1]}}, rd_y});
  assign cx_ext = $signed({{(DIFF_W-CEN_W){cen_x[CEN_W-1]}}, cen_x});
  assign cy_ext = $signed({{(DIFF_W-CEN_W){cen_y[CEN_W-1]}}, cen_y});
  assign px_ext = $signed({{(DIFF_W-31){1'b0}}, cfg.period_x});
  assign py_ext = $signed({{(DIFF_W-31){1'b0}}, cfg.period_y});

  // a negative image offset adds the period to the difference
  always_comb begin
    case (tag2.a)
      OFF_NEG: off_x = px_ext;
      OFF_POS: off_x = -px_ext;
      default: off_x = '0;
    endcase
    case (tag2.b)
      OFF_NEG: off_y = py_ext;
      OFF_POS: off_y = -py_ext;
      default: off_y = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    n1     <= n;
    n2     <= n1;
    n3     <= n2;
    n4     <= n3;
    n5     <= n4;
    base_x <= cx_ext - sx_ext;
    base_y <= cy_ext - sy_ext;
    dx     <= base_x + off_x;
    dy     <= base_y + off_y;
    mag_x  <= dx[DIFF_W-1] ? -dx : dx;
    mag_y  <= dy[DIFF_W-1] ? -dy : dy;
    sat_x  <= |mag_x[DIFF_W-1:32];
    sat_y  <= |mag_y[DIFF_W-1:32];
    sq_x   <= mag_x[31:0] * mag_x[31:0];
    sq_y   <= mag_y[31:0] * mag_y[31:0];
  end

  // saturating sum and first-minimum compare
  logic [SQ_W:0]   sum;
  logic [SQ_W-1:0] cand_dist, best;
  logic [AW-1:0]   best_n;
  logic            take;
  logic [31:0]     best32;

  assign sum       = {1'b0, sq_x} + {1'b0, sq_y};
  assign cand_dist = (sat_x || sat_y || sum[SQ_W]) ? '1 : sum[SQ_W-1:0];
  assign take      = tag5.valid && (!have || (cand_dist < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.start) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_n <= '0;
    end else if (take) begin
      best_n <= n5;
      best   <= cand_dist;
    end
  end

  assign best32   = 32'(best_n);
  assign best_id  = best32[7:0];
  assign sts.done = done_r;

`ifndef SYNTHESIS
  a_have_after_compare: assert property (@(posedge clk) disable iff (rst)
    (tag5.valid && !cmd.start) |=> have)
    else $error("compared image left no best candidate");
`endif

endmodule
